/* rtl/core/siea_pkg.sv */
`default_nettype none

package siea_pkg;

   // Payload field widths
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 6;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 6;

   // Command codes; code 3 is unused and answered with a reject
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_ERASE  = 2'd1,
      CMD_DUMP   = 2'd2
   } cmd_type;

   // Controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_INS   = 5'b00010,
      ST_ERA   = 5'b00100,
      ST_DUMP  = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/siea_if.sv */
`default_nettype none

// Command channel
interface siea_req_if;
   logic                         valid;
   logic                         ready;
   logic [siea_pkg::CMD_W-1:0]   command;
   logic [siea_pkg::IDX_W-1:0]   index;
   logic signed [siea_pkg::DATA_W-1:0] value;

   modport source (output valid, command, index, value, input ready);
   modport sink   (input valid, command, index, value, output ready);
endinterface

// Result channel
interface siea_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic [siea_pkg::COUNT_W-1:0] count;
   logic signed [siea_pkg::DATA_W-1:0] element;
   logic                         has_element;
   logic                         last;

   modport source (output valid, ok, count, element, has_element, last, input ready);
   modport sink   (input valid, ok, count, element, has_element, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/siea_ram.sv */
`default_nettype none

// Element store: one write port, one read port, registered read data
module siea_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [ADDR_W-1:0]                 wr_addr,
   input  wire logic [siea_pkg::DATA_W-1:0]       wr_data,
   input  wire logic                              rd_en,
   input  wire logic [ADDR_W-1:0]                 rd_addr,
   output      logic [siea_pkg::DATA_W-1:0]       rd_data
);

   logic [siea_pkg::DATA_W-1:0] mem [DEPTH];
   logic [siea_pkg::DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port; data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/shift_insert_erase_array_top.sv */
`default_nettype none

// Insert/erase: shifts k elements, k = elements moved (up to CAPACITY-1), then loads the result.
// Each shift reads one element and writes one per cycle.
// Dump: one element per cycle while the result channel is ready; reject/empty dump: a single result.
// One command at a time; the next is taken once the last result is registered.
// Synchronous reset empties the array; stored values are not cleared.
module shift_insert_erase_array_top #(
   parameter int CAPACITY = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   siea_req_if.sink    req_chan,
   siea_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = (CNT_W > siea_pkg::IDX_W) ? CNT_W : siea_pkg::IDX_W;

   siea_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0] wtgt_ff, wtgt_in;
   logic              pend_ff, pend_in;
   logic              plast_ff, plast_in;
   logic              okres_ff, okres_in;
   logic [siea_pkg::DATA_W-1:0] val_ff, val_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_ok_ff, rsp_ok_in;
   logic [siea_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [siea_pkg::DATA_W-1:0]  rsp_elem_ff, rsp_elem_in;
   logic                         rsp_has_ff, rsp_has_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]            mem_wr_addr, mem_rd_addr;
   logic [siea_pkg::DATA_W-1:0]  mem_wr_data, mem_rd_data;

   logic              out_free;
   logic              req_xfer;
   logic [CMP_W-1:0]  idx_ext, cnt_ext;
   logic              dump_issue;

   siea_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == siea_pkg::ST_IDLE);
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign idx_ext = CMP_W'(req_chan.index);
   assign cnt_ext = CMP_W'(count_ff);
   assign dump_issue = (ptr_ff < count_ff) && (!pend_ff || out_free);

   // controller: command decode, shift sequencing, result loading
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      wtgt_in      = wtgt_ff;
      pend_in      = pend_ff;
      plast_in     = plast_ff;
      okres_in     = okres_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      rsp_elem_in  = rsp_elem_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_last_in  = rsp_last_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wtgt_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ADDR_W'(ptr_ff);

      case (state_ff)
         siea_pkg::ST_IDLE: begin
            if (req_xfer) begin
               val_in   = req_chan.value;
               idx_in   = CNT_W'(req_chan.index);
               pend_in  = 1'b0;
               okres_in = 1'b0;
               state_in = siea_pkg::ST_RESP;
               case (siea_pkg::cmd_type'(req_chan.command))
                  siea_pkg::CMD_INSERT: begin
                     if ((idx_ext <= cnt_ext) && (count_ff < CNT_W'(CAPACITY))) begin
                        ptr_in   = count_ff;
                        state_in = siea_pkg::ST_INS;
                     end
                  end
                  siea_pkg::CMD_ERASE: begin
                     if (idx_ext < cnt_ext) begin
                        ptr_in   = CNT_W'(req_chan.index) + CNT_W'(1);
                        state_in = siea_pkg::ST_ERA;
                     end
                  end
                  siea_pkg::CMD_DUMP: begin
                     okres_in = 1'b1;
                     ptr_in   = '0;
                     if (count_ff != '0) begin
                        state_in = siea_pkg::ST_DUMP;
                     end
                  end
                  default: begin
                     okres_in = 1'b0;
                  end
               endcase
            end
         end

         // move elements up, top first: read p-1, write it to p next cycle
         siea_pkg::ST_INS: begin
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (ptr_ff > idx_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ADDR_W'(ptr_ff - CNT_W'(1));
               wtgt_in     = ADDR_W'(ptr_ff);
               ptr_in      = ptr_ff - CNT_W'(1);
               pend_in     = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = ADDR_W'(idx_ff);
               mem_wr_data = val_ff;
               count_in    = count_ff + CNT_W'(1);
               okres_in    = 1'b1;
               state_in    = siea_pkg::ST_RESP;
            end
         end

         // move elements down, bottom first: read p, write it to p-1 next cycle
         siea_pkg::ST_ERA: begin
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (ptr_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ADDR_W'(ptr_ff);
               wtgt_in     = ADDR_W'(ptr_ff - CNT_W'(1));
               ptr_in      = ptr_ff + CNT_W'(1);
               pend_in     = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               count_in = count_ff - CNT_W'(1);
               okres_in = 1'b1;
               state_in = siea_pkg::ST_RESP;
            end
         end

         // stream reads into the output register, stalling on backpressure
         siea_pkg::ST_DUMP: begin
            if (pend_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_count_in = siea_pkg::COUNT_W'(count_ff);
               rsp_elem_in  = mem_rd_data;
               rsp_has_in   = 1'b1;
               rsp_last_in  = plast_ff;
               if (plast_ff) begin
                  state_in = siea_pkg::ST_IDLE;
               end
            end
            if (dump_issue) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ADDR_W'(ptr_ff);
               ptr_in      = ptr_ff + CNT_W'(1);
               pend_in     = 1'b1;
               plast_in    = (ptr_ff == count_ff - CNT_W'(1));
            end else begin
               pend_in = pend_ff && !out_free;
            end
         end

         // single status result
         siea_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = okres_ff;
               rsp_count_in = siea_pkg::COUNT_W'(count_ff);
               rsp_elem_in  = '0;
               rsp_has_in   = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = siea_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = siea_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= siea_pkg::ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      idx_ff       <= idx_in;
      wtgt_ff      <= wtgt_in;
      plast_ff     <= plast_in;
      okres_ff     <= okres_in;
      val_ff       <= val_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
      rsp_elem_ff  <= rsp_elem_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.ok          = rsp_ok_ff;
   assign rsp_chan.count       = rsp_count_ff;
   assign rsp_chan.element     = rsp_elem_ff;
   assign rsp_chan.has_element = rsp_has_ff;
   assign rsp_chan.last        = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == siea_pkg::ST_IDLE) |-> !mem_wr_en)
      else $error("store written while idle");

   a_xfer_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != siea_pkg::ST_IDLE))
      else $error("command transfer did not start work");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == siea_pkg::ST_IDLE) |=> $stable(count_ff))
      else $error("count changed outside a command");
`endif

endmodule

`default_nettype wire

/* tb/siea_array_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow copy of the array and compares
// every result transfer against the oldest predicted result.
module siea_array_checker #(
   parameter int CAPACITY = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic [siea_pkg::CMD_W-1:0]          req_command,
   input  wire logic [siea_pkg::IDX_W-1:0]          req_index,
   input  wire logic signed [siea_pkg::DATA_W-1:0]  req_value,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic                                rsp_ok,
   input  wire logic [siea_pkg::COUNT_W-1:0]        rsp_count,
   input  wire logic signed [siea_pkg::DATA_W-1:0]  rsp_element,
   input  wire logic                                rsp_has_element,
   input  wire logic                                rsp_last,
   output int                                       failures,
   output int                                       outstanding
);
   import siea_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                     ok;
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] element;
      logic                     has_element;
      logic                     last;
   } array_result_t;

   array_result_t            expected_results[$];
   logic signed [DATA_W-1:0] shadow_store[CAPACITY];
   int                       shadow_fill = 0;
   int                       failure_total = 0;

   function automatic void note_failure(input string msg);
      failure_total++;
      if (failure_total <= MAX_REPORTS) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   // Apply one command to the shadow array and queue the results it causes
   function automatic void predict_command(input logic [CMD_W-1:0] cmd,
                                           input logic [IDX_W-1:0] idx,
                                           input logic signed [DATA_W-1:0] val);
      array_result_t res;
      int pos;
      res = '0;
      res.last = 1'b1;
      case (cmd)
         CMD_INSERT: begin
            if (idx <= shadow_fill && shadow_fill < CAPACITY) begin
               for (pos = shadow_fill; pos > idx; pos--) begin
                  shadow_store[pos] = shadow_store[pos-1];
               end
               shadow_store[idx] = val;
               shadow_fill++;
               res.ok = 1'b1;
            end
            res.count = COUNT_W'(shadow_fill);
            expected_results.push_back(res);
         end
         CMD_ERASE: begin
            if (idx < shadow_fill) begin
               for (pos = idx + 1; pos < shadow_fill; pos++) begin
                  shadow_store[pos-1] = shadow_store[pos];
               end
               shadow_fill--;
               res.ok = 1'b1;
            end
            res.count = COUNT_W'(shadow_fill);
            expected_results.push_back(res);
         end
         CMD_DUMP: begin
            res.ok    = 1'b1;
            res.count = COUNT_W'(shadow_fill);
            if (shadow_fill == 0) begin
               expected_results.push_back(res);
            end else begin
               for (pos = 0; pos < shadow_fill; pos++) begin
                  res.element     = shadow_store[pos];
                  res.has_element = 1'b1;
                  res.last        = (pos == shadow_fill - 1);
                  expected_results.push_back(res);
               end
            end
         end
         default: begin
            // unused code: rejected, array untouched
            res.count = COUNT_W'(shadow_fill);
            expected_results.push_back(res);
         end
      endcase
   endfunction

   // Compare one result transfer with the oldest expectation
   function automatic void check_result();
      array_result_t want;
      if (expected_results.size() == 0) begin
         note_failure($sformatf("unexpected result: ok=%0b count=%0d element=%0d has=%0b last=%0b",
                                rsp_ok, rsp_count, rsp_element, rsp_has_element, rsp_last));
         return;
      end
      want = expected_results.pop_front();
      if (rsp_ok !== want.ok || rsp_count !== want.count || rsp_element !== want.element ||
          rsp_has_element !== want.has_element || rsp_last !== want.last) begin
         note_failure($sformatf({"result mismatch: expected ok=%0b count=%0d element=%0d ",
                                 "has=%0b last=%0b, got ok=%0b count=%0d element=%0d ",
                                 "has=%0b last=%0b"},
                                want.ok, want.count, want.element, want.has_element,
                                want.last, rsp_ok, rsp_count, rsp_element,
                                rsp_has_element, rsp_last));
      end
   endfunction

   // Results are checked before the new command is predicted
   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         shadow_fill = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) predict_command(req_command, req_index, req_value);
      end
      failures    <= failure_total;
      outstanding <= expected_results.size();
   end

endmodule

/* tb/shift_insert_erase_array_top_test.sv */
`timescale 1ns / 1ps

module shift_insert_erase_array_top_test;
   import siea_pkg::*;

   localparam int     CAPACITY      = 32;
   localparam int     HALF_PERIOD   = 4;
   localparam int     RESET_CYCLES  = 8;
   localparam int     RANDOM_ITEMS  = 210;
   localparam int     CALM_ITEMS    = 40;
   localparam int     HOLD_CYCLES   = 300;
   localparam int     DRAIN_LIMIT   = 20000;
   localparam int     SETTLE_CYCLES = 2 * CAPACITY + 8;
   localparam longint RUN_LIMIT_NS  = 5_000_000;

   // command code the block does not use
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   logic clock        = 1'b0;
   logic reset        = 1'b1;
   logic calm_phase   = 1'b0;
   logic hold_off_req = 1'b0;
   int   fill_est     = 0;
   int   failures;
   int   outstanding;

   siea_req_if req_chan ();
   siea_rsp_if rsp_chan ();

   shift_insert_erase_array_top #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   siea_array_checker #(
      .CAPACITY (CAPACITY)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_command     (req_chan.command),
      .req_index       (req_chan.index),
      .req_value       (req_chan.value),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_ok          (rsp_chan.ok),
      .rsp_count       (rsp_chan.count),
      .rsp_element     (rsp_chan.element),
      .rsp_has_element (rsp_chan.has_element),
      .rsp_last        (rsp_chan.last),
      .failures        (failures),
      .outstanding     (outstanding)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Random values half the time, else 32'h7FFF_FFFF, 32'h8000_0000, zero or all ones
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Offer one command and wait for its transfer; valid stays high afterwards
   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
      int gap;
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.command <= cmd;
      req_chan.index   <= idx;
      req_chan.value   <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // rough fill level, used to steer the random indexes and to time the hold-off
      if (cmd == CMD_INSERT && idx <= fill_est && fill_est < CAPACITY) fill_est++;
      else if (cmd == CMD_ERASE && idx < fill_est) fill_est--;
   endtask

   // Result side: random stall bursts, one long hold-off on request
   initial begin : rsp_sink
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (calm_phase) begin
            rsp_chan.ready <= 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 20) - 1) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int   roll;
      int   waited;
      logic grow;
      logic hold_done;

      req_chan.valid   = 1'b0;
      req_chan.command = CMD_DUMP;
      req_chan.index   = '0;
      req_chan.value   = '0;
      hold_done        = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty array, edges of the index range, front/middle/end
      send_cmd(CMD_DUMP, 6'd0, 32'h0);              // empty dump
      send_cmd(CMD_ERASE, 6'd0, 32'h0);             // erase on empty
      send_cmd(CMD_INSERT, 6'd1, 32'h1234_5678);    // insert past the end
      send_cmd(CMD_INSERT, 6'd0, 32'h7FFF_FFFF);
      send_cmd(CMD_INSERT, 6'd0, 32'h8000_0000);    // at the front
      send_cmd(CMD_INSERT, 6'd2, 32'hFFFF_FFFF);    // index equal to count
      send_cmd(CMD_INSERT, 6'd1, 32'h0000_0000);    // in the middle
      send_cmd(CMD_INSERT, 6'd63, 32'hA5A5_A5A5);   // far out of range
      send_cmd(CMD_RESERVED, 6'd63, 32'h5A5A_5A5A);
      send_cmd(CMD_DUMP, 6'd63, 32'hFFFF_FFFF);
      send_cmd(CMD_ERASE, 6'd4, 32'h0);             // index equal to count
      send_cmd(CMD_ERASE, 6'd63, 32'h0);
      send_cmd(CMD_ERASE, 6'd3, 32'h0);             // last element
      send_cmd(CMD_ERASE, 6'd0, 32'h0);             // first element
      send_cmd(CMD_DUMP, 6'd0, 32'h0);
      send_cmd(CMD_ERASE, 6'd1, 32'h0);
      send_cmd(CMD_ERASE, 6'd0, 32'h0);             // back to empty
      send_cmd(CMD_DUMP, 6'd0, 32'h0);
      send_cmd(CMD_INSERT, 6'd0, 32'h0000_0001);
      send_cmd(CMD_DUMP, 6'd0, 32'h0);              // single element

      // Random: grow to full, drain to empty, grow again, drain again
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         grow = (n < 60) || (n >= 120 && n < 170);
         if (n >= RANDOM_ITEMS - CALM_ITEMS) calm_phase = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            send_cmd(CMD_RESERVED, IDX_W'($urandom), pick_value());
         end else if (roll < 13) begin
            if (!hold_done && !calm_phase && fill_est >= 20) begin
               hold_off_req = 1'b1;
               hold_done    = 1'b1;
            end
            send_cmd(CMD_DUMP, IDX_W'($urandom), pick_value());
         end else if (roll < 20) begin
            send_cmd(CMD_INSERT, IDX_W'($urandom), pick_value());
         end else if (roll < 26) begin
            send_cmd(CMD_ERASE, IDX_W'($urandom), pick_value());
         end else if (grow ? roll < 94 : roll >= 94) begin
            send_cmd(CMD_INSERT, IDX_W'($urandom_range(0, fill_est)), pick_value());
         end else begin
            send_cmd(CMD_ERASE, IDX_W'(fill_est == 0 ? 0 : $urandom_range(0, fill_est - 1)),
                     pick_value());
         end
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;

      // Drain the remaining results, then let the block settle
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
rtl/core/siea_pkg.sv
rtl/core/siea_if.sv
rtl/core/siea_ram.sv
rtl/core/shift_insert_erase_array_top.sv
tb/siea_array_checker.sv
tb/shift_insert_erase_array_top_test.sv
